/* hdl/light_channel_lease_table_top_assert.svh */
// Assertion macros used by the lease table back end.
// Needs signals named clock and reset in the including module.
`ifndef LIGHT_CHANNEL_LEASE_TABLE_TOP_ASSERT_SVH
`define LIGHT_CHANNEL_LEASE_TABLE_TOP_ASSERT_SVH

// Plain property, checked outside reset
`define LCLT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset
`define LCLT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define LCLT_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/lclt_pkg.sv */
// Shared types, codes and helpers of the light channel lease table.
// No dependencies.
`default_nettype none

package lclt_pkg;

   localparam int LEASE_SLOTS = 16;
   localparam int SLOT_W      = $clog2(LEASE_SLOTS);
   localparam int LEVEL_MAX   = 1000;
   localparam int LVL_W       = 10;
   localparam int PCT_W       = 7;
   localparam int TAG_W       = 48;
   localparam int OWN_W       = 32;
   localparam int MAX_RESULTS = 3;
   localparam int CNT_W       = 2;

   // commands
   localparam logic [2:0] CMD_OPEN      = 3'd0;
   localparam logic [2:0] CMD_CLOSE     = 3'd1;
   localparam logic [2:0] CMD_SET_LEVEL = 3'd2;
   localparam logic [2:0] CMD_SET_RGB   = 3'd3;
   localparam logic [2:0] CMD_CLEAN_OWN = 3'd4;
   localparam logic [2:0] CMD_CLEAN_LSE = 3'd5;

   // status codes
   localparam logic [3:0] ST_OK            = 4'd0;
   localparam logic [3:0] ST_INVALID       = 4'd1;
   localparam logic [3:0] ST_BUSY          = 4'd2;
   localparam logic [3:0] ST_LIMIT         = 4'd3;
   localparam logic [3:0] ST_INTERNAL      = 4'd4;
   localparam logic [3:0] ST_DEADLINE      = 4'd5;
   localparam logic [3:0] ST_WRONG_OWNER   = 4'd6;
   localparam logic [3:0] ST_CANCELLED     = 4'd7;
   localparam logic [3:0] ST_WRONG_CONTEXT = 4'd8;

   // actions
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_PREPARE = 3'd1;
   localparam logic [2:0] ACT_BL_OFF  = 3'd2;
   localparam logic [2:0] ACT_BL_SET  = 3'd3;
   localparam logic [2:0] ACT_ILLUM   = 3'd4;
   localparam logic [2:0] ACT_RGB     = 3'd5;

   // channel bits
   localparam logic [2:0] CH_BL    = 3'd1;
   localparam logic [2:0] CH_ILLUM = 3'd2;
   localparam logic [2:0] CH_RGB   = 3'd4;

   typedef struct packed {
      logic [2:0]       act;
      logic             en;
      logic [PCT_W-1:0] v1;
      logic [PCT_W-1:0] v2;
      logic [PCT_W-1:0] v3;
   } entry_type;

   // decoded command as it travels from front to back
   typedef struct packed {
      logic [2:0]       cmd;
      logic [TAG_W-1:0] tag;
      logic [OWN_W-1:0] owner;
      logic [2:0]       ch;
      logic [PCT_W-1:0] p1;
      logic [PCT_W-1:0] p2;
      logic [PCT_W-1:0] p3;
      logic             l1_nz;
      logic             any_nz;
      logic             dl;
      logic             cx;
      logic             core;
   } work_type;

   // Saturate a level and round it to percent: (min(l,MAX)+5)/10 by reciprocal
   function automatic logic [PCT_W-1:0] level_pct(input logic [LVL_W-1:0] l);
      logic [LVL_W-1:0] s;
      logic [LVL_W:0]   t;
      logic [18:0]      prod;
      s    = (l > LVL_W'(LEVEL_MAX)) ? LVL_W'(LEVEL_MAX) : l;
      t    = {1'b0, s} + 11'd5;
      prod = {8'd0, t} * 19'd205;
      return prod[17:11];
   endfunction

   // Switch-off action for one channel bit
   function automatic logic [2:0] off_act(input logic [1:0] b);
      logic [2:0] a;
      case (b)
         2'd0:    a = ACT_BL_OFF;
         2'd1:    a = ACT_ILLUM;
         2'd2:    a = ACT_RGB;
         default: a = ACT_NONE;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

/* hdl/lclt_front.sv */
// Front end: unpacks requests, saturates and rounds levels, pushes into the queue.
// Depends on lclt_pkg.
`default_nettype none

module lclt_front (
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [119:0]      req_tdata,
   input  wire logic [2:0]        req_tuser,
   input  wire logic              q_ready,
   output logic                   q_push,
   output lclt_pkg::work_type     q_wdata
);
   import lclt_pkg::*;

   logic [LVL_W-1:0] l1, l2, l3;

   assign l1 = req_tdata[92:83];
   assign l2 = req_tdata[102:93];
   assign l3 = req_tdata[112:103];

   // classify and convert the request
   always_comb begin
      q_wdata.cmd    = req_tuser;
      q_wdata.tag    = req_tdata[47:0];
      q_wdata.owner  = req_tdata[79:48];
      q_wdata.ch     = req_tdata[82:80];
      q_wdata.p1     = level_pct(l1);
      q_wdata.p2     = level_pct(l2);
      q_wdata.p3     = level_pct(l3);
      q_wdata.l1_nz  = |l1;
      q_wdata.any_nz = |{l1, l2, l3};
      q_wdata.dl     = req_tdata[113];
      q_wdata.cx     = req_tdata[114];
      q_wdata.core   = req_tdata[115];
   end

   assign req_tready = q_ready;
   assign q_push     = req_tvalid & q_ready;

endmodule

`default_nettype wire

/* hdl/lclt_queue.sv */
// Two-entry queue of decoded requests between front and back.
// Depends on lclt_pkg.
`default_nettype none

module lclt_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire lclt_pkg::work_type wdata,
   output logic                    ready,
   output logic                    valid,
   input  wire logic               pop,
   output lclt_pkg::work_type      rdata
);
   import lclt_pkg::*;

   work_type   mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign ready = (cnt_ff != 2'd2);
   assign valid = (cnt_ff != 2'd0);
   assign rdata = mem_ff[rd_ff];

   // advance pointers and fill count
   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // hold entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

/* hdl/lclt_back.sv */
// Back end: lease table, slot scan sequencer, action list and result register.
// Depends on lclt_pkg and the assertion macro header.
`default_nettype none
`include "light_channel_lease_table_top_assert.svh"

module lclt_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire lclt_pkg::work_type q_rdata,
   output logic                    q_pop,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [31:0]             rsp_tdata,
   output logic [2:0]              rsp_tuser,
   output logic                    rsp_tlast
);
   import lclt_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_PURGE  = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;
   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(LEASE_SLOTS - 1);

   logic [2:0]        state_ff, state_in;
   work_type          work_ff, work_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              found_ff, found_in, free_ff, free_in;
   logic              busy_ff, busy_in, own_ff, own_in;
   logic [SLOT_W-1:0] fidx_ff, fidx_in, eidx_ff, eidx_in;
   logic              drv_ff, drv_in;
   entry_type         list_ff [MAX_RESULTS];
   entry_type         list_in [MAX_RESULTS];
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [3:0]        st_ff, st_in;
   logic [CNT_W-1:0]  emit_ff, emit_in;

   logic              use_ff [LEASE_SLOTS];
   logic [2:0]        chan_ff [LEASE_SLOTS];
   logic [TAG_W-1:0]  tag_mem [LEASE_SLOTS];
   logic [OWN_W-1:0]  own_mem [LEASE_SLOTS];

   logic              rv_ff, rv_in, rl_ff, rl_in;
   entry_type         re_ff, re_in;
   logic [3:0]        rs_ff, rs_in;

   logic              cur_use, cur_own, cur_match;
   logic              set_en, clr_en;
   logic [SLOT_W-1:0] clr_idx;
   logic [2:0]        off_mask;
   logic              off_en;
   entry_type         off_list [MAX_RESULTS];
   logic [CNT_W-1:0]  off_cnt;
   logic [CNT_W-1:0]  n_res;
   logic              load_rsp;

   // current slot under the scan pointer
   assign cur_use   = use_ff[idx_ff];
   assign cur_own   = cur_use && (own_mem[idx_ff] == work_ff.owner);
   assign cur_match = cur_own && (tag_mem[idx_ff] == work_ff.tag);

   // append switch-off actions for off_mask, dropping past the result cap
   always_comb begin
      logic [CNT_W-1:0] c;
      entry_type        e;
      c = cnt_ff;
      for (int k = 0; k < MAX_RESULTS; k++) begin
         off_list[k] = list_ff[k];
      end
      for (int b = 0; b < 3; b++) begin
         e     = '0;
         e.act = off_act(2'(b));
         if (off_en && off_mask[b] && (c < CNT_W'(MAX_RESULTS))) begin
            off_list[c] = e;
            c           = c + 1'b1;
         end
      end
      off_cnt = c;
   end

   assign n_res    = (cnt_ff == '0) ? CNT_W'(1) : cnt_ff;
   assign load_rsp = (state_ff == S_EMIT) && (!rv_ff || rsp_tready);

   // sequencer
   always_comb begin
      entry_type e;
      state_in = state_ff;
      work_in  = work_ff;
      idx_in   = idx_ff;
      found_in = found_ff;
      free_in  = free_ff;
      busy_in  = busy_ff;
      own_in   = own_ff;
      fidx_in  = fidx_ff;
      eidx_in  = eidx_ff;
      drv_in   = drv_ff;
      cnt_in   = cnt_ff;
      st_in    = st_ff;
      emit_in  = emit_ff;
      for (int k = 0; k < MAX_RESULTS; k++) begin
         list_in[k] = list_ff[k];
      end
      q_pop    = 1'b0;
      set_en   = 1'b0;
      clr_en   = 1'b0;
      clr_idx  = idx_ff;
      off_mask = chan_ff[idx_ff];
      off_en   = 1'b0;
      rv_in    = rv_ff && !rsp_tready;
      re_in    = re_ff;
      rs_in    = rs_ff;
      rl_in    = rl_ff;
      e        = '0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               work_in  = q_rdata;
               idx_in   = '0;
               found_in = 1'b0;
               free_in  = 1'b0;
               busy_in  = 1'b0;
               own_in   = 1'b0;
               cnt_in   = '0;
               emit_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // gather first match, first free, overlap and owner presence
            if (cur_match && !found_ff) begin
               found_in = 1'b1;
               fidx_in  = idx_ff;
            end
            if (!cur_use && !free_ff) begin
               free_in = 1'b1;
               eidx_in = idx_ff;
            end
            if (cur_use && |(chan_ff[idx_ff] & work_ff.ch)) begin
               busy_in = 1'b1;
            end
            if (cur_own) begin
               own_in = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_EMIT;
            off_mask = chan_ff[fidx_ff];
            case (work_ff.cmd)
               CMD_OPEN: begin
                  if (work_ff.ch == 3'd0) begin
                     st_in = ST_INVALID;
                  end else if (busy_ff) begin
                     st_in = ST_BUSY;
                  end else if (!free_ff) begin
                     st_in = ST_LIMIT;
                  end else begin
                     st_in  = ST_OK;
                     set_en = 1'b1;
                     if (!drv_ff) begin
                        e.act      = ACT_PREPARE;
                        list_in[0] = e;
                        cnt_in     = CNT_W'(1);
                        drv_in     = 1'b1;
                     end
                  end
               end
               CMD_CLOSE, CMD_CLEAN_LSE: begin
                  if (!found_ff) begin
                     st_in = (work_ff.cmd == CMD_CLOSE) ? ST_INTERNAL : ST_OK;
                  end else if (work_ff.dl) begin
                     st_in = ST_DEADLINE;
                  end else begin
                     st_in   = ST_OK;
                     off_en  = 1'b1;
                     clr_en  = 1'b1;
                     clr_idx = fidx_ff;
                     for (int k = 0; k < MAX_RESULTS; k++) begin
                        list_in[k] = off_list[k];
                     end
                     cnt_in = off_cnt;
                  end
               end
               CMD_SET_LEVEL: begin
                  if (!found_ff) begin
                     st_in = ST_INTERNAL;
                  end else if ((chan_ff[fidx_ff] & work_ff.ch) != work_ff.ch) begin
                     st_in = ST_WRONG_OWNER;
                  end else if (work_ff.cx) begin
                     st_in = ST_CANCELLED;
                  end else if (work_ff.dl) begin
                     st_in = ST_DEADLINE;
                  end else if (work_ff.ch == CH_BL) begin
                     st_in      = ST_OK;
                     e.act      = work_ff.l1_nz ? ACT_BL_SET : ACT_BL_OFF;
                     e.v1       = work_ff.l1_nz ? work_ff.p1 : '0;
                     list_in[0] = e;
                     cnt_in     = CNT_W'(1);
                  end else if (work_ff.ch == CH_ILLUM) begin
                     st_in      = ST_OK;
                     e.act      = ACT_ILLUM;
                     e.en       = work_ff.l1_nz;
                     e.v1       = work_ff.p1;
                     list_in[0] = e;
                     cnt_in     = CNT_W'(1);
                  end else begin
                     st_in = ST_INVALID;
                  end
               end
               CMD_SET_RGB: begin
                  if (!found_ff) begin
                     st_in = ST_INTERNAL;
                  end else if ((chan_ff[fidx_ff] & CH_RGB) != CH_RGB) begin
                     st_in = ST_WRONG_OWNER;
                  end else if (work_ff.cx) begin
                     st_in = ST_CANCELLED;
                  end else if (work_ff.dl) begin
                     st_in = ST_DEADLINE;
                  end else begin
                     st_in      = ST_OK;
                     e.act      = ACT_RGB;
                     e.en       = work_ff.any_nz;
                     e.v1       = work_ff.p1;
                     e.v2       = work_ff.p2;
                     e.v3       = work_ff.p3;
                     list_in[0] = e;
                     cnt_in     = CNT_W'(1);
                  end
               end
               CMD_CLEAN_OWN: begin
                  if (work_ff.core) begin
                     st_in = ST_WRONG_CONTEXT;
                  end else if (own_ff && work_ff.dl) begin
                     st_in = ST_DEADLINE;
                  end else begin
                     st_in    = ST_OK;
                     idx_in   = '0;
                     state_in = S_PURGE;
                  end
               end
               default: begin
                  st_in = ST_INVALID;
               end
            endcase
         end
         S_PURGE: begin
            // free every lease of the owner, ascending
            if (cur_own) begin
               off_en  = 1'b1;
               clr_en  = 1'b1;
               for (int k = 0; k < MAX_RESULTS; k++) begin
                  list_in[k] = off_list[k];
               end
               cnt_in = off_cnt;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (load_rsp) begin
               rv_in = 1'b1;
               re_in = (cnt_ff == '0) ? entry_type'('0) : list_ff[emit_ff];
               rl_in = (emit_ff == n_res - 1'b1);
               rs_in = (emit_ff == n_res - 1'b1) ? st_ff : ST_OK;
               emit_in = emit_ff + 1'b1;
               if (emit_ff == n_res - 1'b1) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         drv_ff   <= 1'b0;
         rv_ff    <= 1'b0;
         cnt_ff   <= '0;
         emit_ff  <= '0;
         for (int i = 0; i < LEASE_SLOTS; i++) begin
            use_ff[i]  <= 1'b0;
            chan_ff[i] <= 3'd0;
         end
      end else begin
         state_ff <= state_in;
         drv_ff   <= drv_in;
         rv_ff    <= rv_in;
         cnt_ff   <= cnt_in;
         emit_ff  <= emit_in;
         if (set_en) begin
            use_ff[eidx_ff]  <= 1'b1;
            chan_ff[eidx_ff] <= work_ff.ch;
         end
         if (clr_en) begin
            use_ff[clr_idx]  <= 1'b0;
            chan_ff[clr_idx] <= 3'd0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      idx_ff   <= idx_in;
      found_ff <= found_in;
      free_ff  <= free_in;
      busy_ff  <= busy_in;
      own_ff   <= own_in;
      fidx_ff  <= fidx_in;
      eidx_ff  <= eidx_in;
      st_ff    <= st_in;
      re_ff    <= re_in;
      rs_ff    <= rs_in;
      rl_ff    <= rl_in;
      for (int k = 0; k < MAX_RESULTS; k++) begin
         list_ff[k] <= list_in[k];
      end
      if (set_en) begin
         tag_mem[eidx_ff] <= work_ff.tag;
         own_mem[eidx_ff] <= work_ff.owner;
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {6'd0, re_ff.v3, re_ff.v2, re_ff.v1, re_ff.en, rs_ff};
   assign rsp_tuser  = re_ff.act;
   assign rsp_tlast  = rl_ff;

   // channels of open leases never overlap
   logic chan_overlap;
   always_comb begin
      logic [2:0] acc;
      acc          = 3'd0;
      chan_overlap = 1'b0;
      for (int i = 0; i < LEASE_SLOTS; i++) begin
         if (use_ff[i]) begin
            chan_overlap = chan_overlap | (|(acc & chan_ff[i]));
            acc          = acc | chan_ff[i];
         end
      end
   end

   `LCLT_ASSERT(a_no_overlap, !chan_overlap, "open leases share a channel")
   `LCLT_ASSERT_IMP(a_emit_range, state_ff == S_EMIT, emit_ff < n_res, "emit index past list")
   `LCLT_ASSERT_IMP(a_prepare_once, $rose(drv_ff), list_ff[0].act == ACT_PREPARE, "no prepare")
   `LCLT_ASSERT_NXT(a_scan_end, state_ff == S_SCAN && idx_ff == LAST_IDX,
      state_ff == S_DECIDE, "scan did not end")

endmodule

`default_nettype wire

/* hdl/light_channel_lease_table_top.sv */
// Lease table over backlight, illumination and RGB channels: open, close, set
// level or RGB, and cleanup by owner or lease. Each request is taken from the
// queue, then a scan of the slot table follows (one slot per cycle), then a
// decision step. Cleanup by owner adds a second pass over the slots. Then the
// results (one to three) are sent in order, and a stalled result holds the
// back end. A two-entry queue lets new requests be taken while the back end
// works. Results carry the action in rsp_tuser and the status on the result
// flagged by rsp_tlast.
// Depends on lclt_pkg, lclt_front, lclt_queue and lclt_back.
`default_nettype none

module light_channel_lease_table_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // lease_tag[47:0], owner_id[79:48], channel_mask[82:80], level_or_red[92:83],
   // green_level[102:93], blue_level[112:103], deadline_passed[113],
   // cancel_requested[114], core_select[115]
   input  wire logic [119:0] req_tdata,
   // command[2:0]
   input  wire logic [2:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[3:0], drive_enable[4], value_first[11:5], value_second[18:12],
   // value_third[25:19]
   output logic [31:0]       rsp_tdata,
   // action[2:0]
   output logic [2:0]        rsp_tuser,
   output logic              rsp_tlast
);
   import lclt_pkg::*;

   work_type q_wdata, q_rdata;
   logic     q_push, q_ready, q_valid, q_pop;

   lclt_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   lclt_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .ready (q_ready),
      .valid (q_valid),
      .pop   (q_pop),
      .rdata (q_rdata)
   );

   lclt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_rdata    (q_rdata),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking bench for the light channel lease table: a directed table, then random
// lease traffic, with every result checked against a built-in lease table predictor.
// Depends on lclt_pkg and light_channel_lease_table_top.
`default_nettype none

module tb;
   import lclt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_PCT   = 20;
   localparam int RAND_ITEMS = 176;
   localparam int STALL_LIM  = 4000;

   typedef struct {
      logic [2:0]       cmd;
      logic [TAG_W-1:0] tag;
      logic [OWN_W-1:0] owner;
      logic [2:0]       mask;
      logic [LVL_W-1:0] l1, l2, l3;
      logic             dl, cx, core;
   } request_type;

   typedef struct {
      logic [3:0]       status;
      logic [2:0]       act;
      logic             en;
      logic [PCT_W-1:0] v1, v2, v3;
      logic             last;
   } light_result_type;

   // directed row: request plus the final status typed in where obvious
   typedef struct {
      request_type rq;
      bit          known;
      logic [3:0]  status;
   } row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [119:0]       req_tdata = '0;
   logic [2:0]         req_tuser = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [31:0]        rsp_tdata;
   logic [2:0]         rsp_tuser;
   logic               rsp_tlast;

   // predictor copy of the lease table
   bit                 lease_used [LEASE_SLOTS];
   logic [TAG_W-1:0]   lease_tag  [LEASE_SLOTS];
   logic [OWN_W-1:0]   lease_own  [LEASE_SLOTS];
   logic [2:0]         lease_ch   [LEASE_SLOTS];
   bit                 driver_up;

   light_result_type   expected_lights[$];
   light_result_type   staged[$];
   int                 errors = 0;
   int                 idle_cycles = 0;
   bit                 calm = 1'b0;
   logic [TAG_W-1:0]   tag_pool [4];
   logic [OWN_W-1:0]   own_pool [3];

   light_channel_lease_table_top dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [PCT_W-1:0] to_pct(input logic [LVL_W-1:0] l);
      int s;
      s = (l > LEVEL_MAX) ? LEVEL_MAX : int'(l);
      return PCT_W'((s + 5) / 10);
   endfunction

   function automatic void stage(input logic [2:0] a, input logic e,
                                 input logic [PCT_W-1:0] x, y, z);
      light_result_type r;
      if (staged.size() >= MAX_RESULTS) return;
      r = '{status: ST_OK, act: a, en: e, v1: x, v2: y, v3: z, last: 1'b0};
      staged.push_back(r);
   endfunction

   function automatic void switch_off(input int i);
      if (lease_ch[i] & CH_BL)    stage(ACT_BL_OFF, 0, 0, 0, 0);
      if (lease_ch[i] & CH_ILLUM) stage(ACT_ILLUM, 0, 0, 0, 0);
      if (lease_ch[i] & CH_RGB)   stage(ACT_RGB, 0, 0, 0, 0);
      lease_used[i] = 0;
      lease_ch[i]   = '0;
   endfunction

   function automatic int lookup_slot(input request_type rq);
      for (int i = 0; i < LEASE_SLOTS; i++)
         if (lease_used[i] && lease_tag[i] == rq.tag && lease_own[i] == rq.owner) return i;
      return -1;
   endfunction

   // gate a write: lease found, then ownership, then cancel, then deadline
   function automatic logic [3:0] write_gate(input int s, input logic [2:0] m,
                                             input request_type rq);
      if (s < 0) return ST_INTERNAL;
      if ((lease_ch[s] & m) != m) return ST_WRONG_OWNER;
      if (rq.cx) return ST_CANCELLED;
      if (rq.dl) return ST_DEADLINE;
      return ST_OK;
   endfunction

   // update the lease table and queue the results; return the final status
   function automatic logic [3:0] predict_lights(input request_type rq);
      logic [3:0]       st;
      int               s, fs;
      bit               hit;
      light_result_type r;
      staged.delete();
      st = ST_INVALID;
      case (rq.cmd)
         CMD_OPEN: begin
            fs = -1;
            hit = 0;
            for (int i = 0; i < LEASE_SLOTS; i++) begin
               if (!lease_used[i]) begin
                  if (fs < 0) fs = i;
               end else if (lease_ch[i] & rq.mask) hit = 1;
            end
            if (rq.mask == 0) st = ST_INVALID;
            else if (hit) st = ST_BUSY;
            else if (fs < 0) st = ST_LIMIT;
            else begin
               if (!driver_up) begin
                  stage(ACT_PREPARE, 0, 0, 0, 0);
                  driver_up = 1;
               end
               lease_used[fs] = 1;
               lease_tag[fs]  = rq.tag;
               lease_own[fs]  = rq.owner;
               lease_ch[fs]   = rq.mask;
               st = ST_OK;
            end
         end
         CMD_CLOSE, CMD_CLEAN_LSE: begin
            s = lookup_slot(rq);
            if (s < 0) st = (rq.cmd == CMD_CLOSE) ? ST_INTERNAL : ST_OK;
            else if (rq.dl) st = ST_DEADLINE;
            else begin
               switch_off(s);
               st = ST_OK;
            end
         end
         CMD_SET_LEVEL: begin
            st = write_gate(lookup_slot(rq), rq.mask, rq);
            if (st == ST_OK) begin
               if (rq.mask == CH_BL) begin
                  if (rq.l1 == 0) stage(ACT_BL_OFF, 0, 0, 0, 0);
                  else stage(ACT_BL_SET, 0, to_pct(rq.l1), 0, 0);
               end else if (rq.mask == CH_ILLUM) begin
                  stage(ACT_ILLUM, rq.l1 != 0, to_pct(rq.l1), 0, 0);
               end else begin
                  st = ST_INVALID;
               end
            end
         end
         CMD_SET_RGB: begin
            st = write_gate(lookup_slot(rq), CH_RGB, rq);
            if (st == ST_OK)
               stage(ACT_RGB, (rq.l1 | rq.l2 | rq.l3) != 0,
                     to_pct(rq.l1), to_pct(rq.l2), to_pct(rq.l3));
         end
         CMD_CLEAN_OWN: begin
            hit = 0;
            for (int i = 0; i < LEASE_SLOTS; i++)
               if (lease_used[i] && lease_own[i] == rq.owner) hit = 1;
            if (rq.core) st = ST_WRONG_CONTEXT;
            else if (hit && rq.dl) st = ST_DEADLINE;
            else begin
               for (int i = 0; i < LEASE_SLOTS; i++)
                  if (lease_used[i] && lease_own[i] == rq.owner) switch_off(i);
               st = ST_OK;
            end
         end
         default: st = ST_INVALID;
      endcase
      if (staged.size() == 0) begin
         r = '{status: ST_OK, act: ACT_NONE, en: 0, v1: 0, v2: 0, v3: 0, last: 0};
         staged.push_back(r);
      end
      staged[staged.size()-1].status = st;
      staged[staged.size()-1].last   = 1'b1;
      foreach (staged[k]) expected_lights.push_back(staged[k]);
      return st;
   endfunction

   // present one request and hold it until it is taken
   task automatic send_request(input request_type rq, output logic [3:0] st);
      int gap;
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= rq.cmd;
      req_tdata  <= {4'b0, rq.core, rq.cx, rq.dl, rq.l3, rq.l2, rq.l1,
                     rq.mask, rq.owner, rq.tag};
      do @(posedge clock); while (!req_tready);
      st = predict_lights(rq);
   endtask

   function automatic request_type mk(input logic [2:0] c, input logic [TAG_W-1:0] t,
                                      input logic [OWN_W-1:0] o, input logic [2:0] m,
                                      input logic [LVL_W-1:0] a, b, d,
                                      input logic dl, cx, core);
      request_type rq;
      rq = '{cmd: c, tag: t, owner: o, mask: m, l1: a, l2: b, l3: d,
             dl: dl, cx: cx, core: core};
      return rq;
   endfunction

   function automatic logic [LVL_W-1:0] rand_level();
      case ($urandom_range(5))
         0:       return '0;
         1:       return LVL_W'(LEVEL_MAX);
         2:       return LVL_W'($urandom_range(1023, 1001));
         default: return LVL_W'($urandom_range(1023));
      endcase
   endfunction

   // random request: mostly aimed at open leases, some noise
   function automatic request_type rand_request();
      request_type rq;
      int          pick, s;
      int          live[$];
      rq.cmd  = 3'($urandom_range(5));
      pick    = $urandom_range(99);
      if (pick < 25) rq.cmd = CMD_OPEN;
      else if (pick < 50) rq.cmd = CMD_SET_LEVEL;
      else if (pick < 65) rq.cmd = CMD_SET_RGB;
      else if (pick < 75) rq.cmd = CMD_CLOSE;
      else if (pick < 85) rq.cmd = CMD_CLEAN_LSE;
      else if (pick < 94) rq.cmd = CMD_CLEAN_OWN;
      else if (pick < 97) rq.cmd = 3'($urandom_range(7, 6));
      rq.tag   = tag_pool[$urandom_range(3)];
      rq.owner = own_pool[$urandom_range(2)];
      rq.mask  = 3'($urandom_range(7, 1));
      rq.l1    = rand_level();
      rq.l2    = rand_level();
      rq.l3    = rand_level();
      rq.dl    = ($urandom_range(9) == 0);
      rq.cx    = ($urandom_range(9) == 0);
      rq.core  = ($urandom_range(9) == 0);
      for (int i = 0; i < LEASE_SLOTS; i++) if (lease_used[i]) live.push_back(i);
      if (rq.cmd != CMD_OPEN && live.size() > 0 && $urandom_range(9) < 8) begin
         s = live[$urandom_range(live.size() - 1)];
         rq.tag   = lease_tag[s];
         rq.owner = lease_own[s];
         if (rq.cmd == CMD_SET_LEVEL && $urandom_range(3) != 0) begin
            if (lease_ch[s] & CH_BL) rq.mask = CH_BL;
            else if (lease_ch[s] & CH_ILLUM) rq.mask = CH_ILLUM;
            else rq.mask = lease_ch[s];
         end
      end
      if ($urandom_range(19) == 0) begin
         rq.tag   = TAG_W'({$urandom, $urandom});
         rq.owner = $urandom;
         rq.mask  = 3'($urandom_range(7));
      end
      return rq;
   endfunction

   // check each result against the oldest expectation
   always @(posedge clock) begin
      light_result_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_lights.size() == 0) begin
               $error("unexpected result action=%0d", rsp_tuser);
               errors++;
            end else begin
               e = expected_lights.pop_front();
               if (rsp_tdata[3:0] !== e.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_tdata[3:0]);
                  errors++;
               end
               if (rsp_tuser !== e.act) begin
                  $error("action exp %0d got %0d", e.act, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata[4] !== e.en) begin
                  $error("drive_enable exp %0d got %0d", e.en, rsp_tdata[4]);
                  errors++;
               end
               if (rsp_tdata[11:5] !== e.v1) begin
                  $error("value_first exp %0d got %0d", e.v1, rsp_tdata[11:5]);
                  errors++;
               end
               if (rsp_tdata[18:12] !== e.v2) begin
                  $error("value_second exp %0d got %0d", e.v2, rsp_tdata[18:12]);
                  errors++;
               end
               if (rsp_tdata[25:19] !== e.v3) begin
                  $error("value_third exp %0d got %0d", e.v3, rsp_tdata[25:19]);
                  errors++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("last_result exp %0d got %0d", e.last, rsp_tlast);
                  errors++;
               end
            end
         end
         rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else if (!reset) idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIM) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      row_type          rows[$];
      request_type      rq;
      logic [3:0]       st;
      logic [TAG_W-1:0] t1;
      logic [OWN_W-1:0] o1;
      t1 = '1;
      o1 = '1;
      foreach (tag_pool[i]) tag_pool[i] = TAG_W'({$urandom, $urandom});
      foreach (own_pool[i]) own_pool[i] = $urandom;
      tag_pool[0] = '0;
      own_pool[0] = '1;
      foreach (lease_used[i]) begin
         lease_used[i] = 0;
         lease_ch[i]   = '0;
      end
      driver_up = 0;

      rows = '{
         '{mk(CMD_OPEN, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_INVALID},
         '{mk(CMD_OPEN, 0, 0, CH_BL, 0, 0, 0, 1, 1, 0), 1, ST_OK},
         '{mk(CMD_OPEN, t1, 0, CH_BL, 0, 0, 0, 0, 0, 0), 1, ST_BUSY},
         '{mk(CMD_SET_LEVEL, 0, 0, CH_BL, 0, 0, 0, 0, 0, 0), 1, ST_OK},
         '{mk(CMD_SET_LEVEL, 0, 0, CH_BL, 1023, 0, 0, 0, 0, 0), 1, ST_OK},
         '{mk(CMD_SET_LEVEL, 0, 0, CH_BL, 4, 0, 0, 0, 0, 0), 0, ST_OK},
         '{mk(CMD_SET_LEVEL, 0, 0, CH_ILLUM, 500, 0, 0, 0, 0, 0), 1, ST_WRONG_OWNER},
         '{mk(CMD_OPEN, t1, o1, 3'd6, 0, 0, 0, 0, 0, 0), 1, ST_OK},
         '{mk(CMD_SET_LEVEL, t1, o1, 3'd6, 300, 0, 0, 0, 0, 0), 1, ST_INVALID},
         '{mk(CMD_SET_LEVEL, t1, o1, 3'd0, 300, 0, 0, 0, 0, 0), 1, ST_INVALID},
         '{mk(CMD_SET_LEVEL, t1, o1, CH_ILLUM, 0, 0, 0, 0, 0, 0), 0, ST_OK},
         '{mk(CMD_SET_RGB, t1, o1, 0, 1000, 0, 5, 1, 1, 0), 1, ST_CANCELLED},
         '{mk(CMD_SET_RGB, t1, o1, 0, 1000, 0, 5, 1, 0, 0), 1, ST_DEADLINE},
         '{mk(CMD_SET_RGB, t1, o1, 0, 1023, 4, 15, 0, 0, 1), 0, ST_OK},
         '{mk(CMD_SET_RGB, t1, 0, 0, 10, 10, 10, 0, 0, 0), 1, ST_INTERNAL},
         '{mk(3'd6, 0, 0, 7, 0, 0, 0, 0, 0, 0), 1, ST_INVALID},
         '{mk(3'd7, t1, o1, 7, 1023, 1023, 1023, 1, 1, 1), 1, ST_INVALID},
         '{mk(CMD_CLOSE, 0, 0, 0, 0, 0, 0, 1, 0, 0), 1, ST_DEADLINE},
         '{mk(CMD_CLEAN_OWN, 0, o1, 0, 0, 0, 0, 0, 0, 1), 1, ST_WRONG_CONTEXT},
         '{mk(CMD_CLEAN_OWN, 0, o1, 0, 0, 0, 0, 1, 0, 0), 1, ST_DEADLINE},
         '{mk(CMD_CLEAN_OWN, 0, o1, 0, 0, 0, 0, 0, 0, 0), 1, ST_OK},
         '{mk(CMD_CLEAN_LSE, 0, o1, 0, 0, 0, 0, 0, 0, 0), 1, ST_OK},
         '{mk(CMD_CLEAN_LSE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_OK},
         '{mk(CMD_CLOSE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_INTERNAL}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (rows[i]) begin
         send_request(rows[i].rq, st);
         if (rows[i].known && st !== rows[i].status) begin
            $error("table row %0d status exp %0d got %0d", i, rows[i].status, st);
            errors++;
         end
      end

      // random lease traffic, with a calm stretch in the middle
      for (int n = 0; n < RAND_ITEMS; n++) begin
         calm = (n >= 80 && n < 130);
         rq = rand_request();
         send_request(rq, st);
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      while (expected_lights.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0 && expected_lights.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
